// File: rtl/core/lwo_pkg.sv
// ----------------------------------------------------------------------------
// lwo_pkg: shared types and constants for the white overlay envelope
// Beat payload structs, register indices, controller commands and sizes.
// ----------------------------------------------------------------------------
package lwo_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DvdW     = MsW + LevelW;
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [LevelW-1:0]  LevelMax     = 8'd255;
  localparam logic [MsW-1:0]     AttackReset  = 16'd200;
  localparam logic [MsW-1:0]     ReleaseReset = 16'd400;

  localparam logic [CfgIdxW-1:0] RegAttack  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRelease = 2'd1;

  localparam logic CmdTick  = 1'b0;
  localparam logic CmdPixel = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic              target_on;
    logic [MsW-1:0]    elapsed_ms;
    logic [ChanW-1:0]  red_in;
    logic [ChanW-1:0]  green_in;
    logic [ChanW-1:0]  blue_in;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]  red_out;
    logic [ChanW-1:0]  green_out;
    logic [ChanW-1:0]  blue_out;
    logic [LevelW-1:0] overlay_level;
  } out_item_t;

  typedef struct packed {
    logic load_pixel;
    logic load_tick;
    logic div_step;
    logic finish_tick;
  } dp_cmd_t;

endpackage

// File: rtl/core/lwo_ctrl.sv
// ----------------------------------------------------------------------------
// lwo_ctrl: sequencer for the white overlay envelope
// Handles both handshakes, the output beat register and the divide count.
// ----------------------------------------------------------------------------
module lwo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lwo_pkg::dp_cmd_t dp_cmd_o
);
  import lwo_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;
  logic            accept;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    dp_cmd_o    = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_cmd_i == CmdPixel) begin
            dp_cmd_o.load_pixel = 1'b1;
            out_valid_d         = 1'b1;
          end else begin
            dp_cmd_o.load_tick = 1'b1;
            cnt_d              = '0;
            state_d            = StDiv;
          end
        end
      end
      StDiv: begin
        dp_cmd_o.div_step = 1'b1;
        cnt_d             = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          dp_cmd_o.finish_tick = 1'b1;
          out_valid_d          = 1'b1;
          state_d              = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/lwo_datapath.sv
// ----------------------------------------------------------------------------
// lwo_datapath: envelope level, fade registers, divider and pixel adders
// Restoring divider gives one quotient bit per cycle for the fade step.
// ----------------------------------------------------------------------------
module lwo_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lwo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lwo_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  lwo_pkg::in_item_t            in_data_i,
  input  lwo_pkg::dp_cmd_t             dp_cmd_i,
  output lwo_pkg::out_item_t           out_data_o
);
  import lwo_pkg::*;

  logic [MsW-1:0]    attack_q, release_q;
  logic [LevelW-1:0] level_q, level_d;
  logic [MsW-1:0]    div_q;
  logic [MsW-1:0]    rem_q, rem_d;
  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic              target_q;
  out_item_t         out_q, out_d;

  logic [MsW-1:0]    period;
  logic [DvdW-1:0]   scaled;
  logic [MsW:0]      trial;
  logic [MsW:0]      diff;
  logic [LevelW-1:0] step;
  logic [LevelW:0]   up_sum;

  // zero period divides as one
  assign period = in_data_i.target_on ? attack_q : release_q;
  assign scaled = {in_data_i.elapsed_ms, {LevelW{1'b0}}} - DvdW'(in_data_i.elapsed_ms);

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (dp_cmd_i.load_tick) begin
      rem_d = '0;
      dvd_d = scaled;
    end else if (dp_cmd_i.div_step) begin
      if (!diff[MsW]) begin
        rem_d = diff[MsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[MsW-1:0];
        dvd_d = {dvd_q[DvdW-2:0], 1'b0};
      end
    end
  end

  // clamp the quotient to a full level swing
  assign step   = (dvd_q[DvdW-1:LevelW] != '0) ? LevelMax : dvd_q[LevelW-1:0];
  assign up_sum = {1'b0, level_q} + {1'b0, step};

  always_comb begin
    level_d = level_q;
    if (dp_cmd_i.finish_tick) begin
      if (target_q) begin
        level_d = up_sum[LevelW] ? LevelMax : up_sum[LevelW-1:0];
      end else begin
        level_d = (step >= level_q) ? '0 : level_q - step;
      end
    end
  end

  function automatic logic [ChanW-1:0] sat_add(input logic [ChanW-1:0] a,
                                               input logic [LevelW-1:0] b);
    logic [ChanW:0] s;
    s = {1'b0, a} + (ChanW + 1)'(b);
    return s[ChanW] ? {ChanW{1'b1}} : s[ChanW-1:0];
  endfunction

  always_comb begin
    out_d = out_q;
    if (dp_cmd_i.load_pixel) begin
      out_d.red_out       = sat_add(in_data_i.red_in, level_q);
      out_d.green_out     = sat_add(in_data_i.green_in, level_q);
      out_d.blue_out      = sat_add(in_data_i.blue_in, level_q);
      out_d.overlay_level = level_q;
    end else if (dp_cmd_i.finish_tick) begin
      out_d.red_out       = '0;
      out_d.green_out     = '0;
      out_d.blue_out      = '0;
      out_d.overlay_level = level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= AttackReset;
      release_q <= ReleaseReset;
      level_q   <= '0;
    end else begin
      level_q <= level_d;
      if (cfg_we_i && cfg_idx_i == RegAttack) begin
        attack_q <= cfg_wdata_i[MsW-1:0];
      end
      if (cfg_we_i && cfg_idx_i == RegRelease) begin
        release_q <= cfg_wdata_i[MsW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    out_q <= out_d;
    if (dp_cmd_i.load_tick) begin
      div_q    <= (period == '0) ? MsW'(1) : period;
      target_q <= in_data_i.target_on;
    end
  end

  assign out_data_o = out_q;

endmodule

// File: rtl/core/led_white_overlay_envelope.sv
// ----------------------------------------------------------------------------
// led_white_overlay_envelope: white overlay with attack/release envelope
// Adds a fading white level to a pixel stream, driven by tick beats.
// ----------------------------------------------------------------------------
// usage
//   in channel: valid/ready beats; cmd selects tick (envelope update) or pixel
//   out channel: valid/ready beats, one result per input beat, in order
//   pixel beat: result registered at acceptance, valid the cycle after; pixels stream
//     at one per cycle while the receiver keeps up
//   tick beat: 255*elapsed is divided by the fade time in a restoring divider,
//     one quotient bit per cycle, then the step is applied once the out
//     register is free; no new beat is taken until the tick finishes
//   configuration: write enable, index and data; index 0 attack time,
//     index 1 release time, other indices ignored; write only when idle
//   reset: level cleared to zero, attack 200 ms, release 400 ms, out idle
//   stall: a held result keeps its beat; a new pixel is taken in the cycle
//     the held one leaves, a finished tick waits for the out register
// ----------------------------------------------------------------------------
module led_white_overlay_envelope (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lwo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lwo_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lwo_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lwo_pkg::out_item_t           out_data_o
);
  import lwo_pkg::*;

  dp_cmd_t dp_cmd;

  lwo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd)
  );

  lwo_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .dp_cmd_i    (dp_cmd),
    .out_data_o  (out_data_o)
  );

endmodule
